// ===== rtl/core/sprite_slot_allocator_defines.svh =====
// Assertion macros shared by the sprite slot allocator modules.
// Needs nothing else; include it inside a module body before use.
`ifndef SPRITE_SLOT_ALLOCATOR_DEFINES_SVH
`define SPRITE_SLOT_ALLOCATOR_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define SSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ssa_pkg.sv =====
// Shared types and constants for the sprite slot allocator.
// Used by ssa_ctrl, ssa_datapath and sprite_slot_allocator; depends on nothing.
package ssa_pkg;

    localparam int SSA_SLOT_COUNT = 16;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OAM_W    = 5;
    localparam int TOTAL_W  = 5;

    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                latch_in;
        logic                pool_reset;
        logic                alloc_rd;
        logic                alloc_commit;
        logic                push;
        logic                search_start;
        logic                search_issue;
        logic                swap_rd;
        logic                swap_commit;
        logic                load_result;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             slot_oob;
        logic             free_empty;
        logic             active_full;
        logic             more;
        logic             hit;
        logic             ovf;
    } t_dp_sts;

endpackage

// ===== rtl/core/ssa_datapath.sv =====
// Datapath of the sprite slot allocator: free stack, active list, counters, result.
// Depends on ssa_pkg and sprite_slot_allocator_defines.svh.
module ssa_datapath
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SSA_SLOT_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SLOT_W-1:0]   i_slot_id,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_granted_slot,
    output logic                o_hide_valid,
    output logic [OAM_W-1:0]    o_hide_oam_index,
    output logic [TOTAL_W-1:0]  o_active_total
);
    `include "sprite_slot_allocator_defines.svh"

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    logic [CMD_W-1:0]    r_cmd;
    logic [SLOT_W-1:0]   r_slot;

    logic [IDX_W-1:0]    r_free_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_free_vld;
    logic [CNT_W-1:0]    r_free_cnt;
    logic [IDX_W-1:0]    r_free_rd;
    logic                r_ovf;

    logic [IDX_W-1:0]    r_act_mem [SLOT_COUNT];
    logic [CNT_W-1:0]    r_act_cnt;
    logic [IDX_W-1:0]    r_act_rd;
    logic [CNT_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;

    logic [SLOT_W-1:0]   r_granted;
    logic                r_hide;

    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_granted;
    logic                r_out_hide;
    logic [OAM_W-1:0]    r_out_oam;
    logic [TOTAL_W-1:0]  r_out_total;

    logic [CNT_W-1:0]    w_free_m1;
    logic [CNT_W-1:0]    w_act_m1;
    logic [IDX_W-1:0]    w_free_top;
    logic [IDX_W-1:0]    w_act_last;
    logic [IDX_W-1:0]    w_slot_idx;
    logic [IDX_W-1:0]    w_act_rd_addr;
    logic [IDX_W-1:0]    w_act_wr_addr;
    logic [IDX_W-1:0]    w_act_wr_data;
    logic                w_free_full;
    logic                w_do_push;

    assign w_free_m1     = r_free_cnt - CNT_W'(1);
    assign w_act_m1      = r_act_cnt - CNT_W'(1);
    assign w_free_top    = w_free_m1[IDX_W-1:0];
    assign w_act_last    = w_act_m1[IDX_W-1:0];
    assign w_slot_idx    = IDX_W'(r_slot);
    assign w_free_full   = (r_free_cnt == CNT_MAX);
    assign w_do_push     = i_cmd.push && !w_free_full;
    assign w_act_rd_addr = i_cmd.swap_rd ? w_act_last : r_idx[IDX_W-1:0];
    assign w_act_wr_addr = i_cmd.alloc_commit ? r_act_cnt[IDX_W-1:0] : r_cmp_idx;
    assign w_act_wr_data = i_cmd.alloc_commit ? r_free_rd : r_act_rd;

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.slot_oob    = (32'(r_slot) >= 32'(SLOT_COUNT));
        o_sts.free_empty  = (r_free_cnt == '0);
        o_sts.active_full = (r_act_cnt == CNT_MAX);
        o_sts.more        = (r_idx < r_act_cnt);
        o_sts.hit         = r_cmp_vld && (r_act_rd == w_slot_idx);
        o_sts.ovf         = r_ovf;
    end

    // Input item and per-item scratch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd  <= i_command;
            r_slot <= i_slot_id;
        end
        if (i_cmd.latch_in) begin
            r_granted <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_granted <= SLOT_W'(r_free_rd);
        end
        if (i_cmd.latch_in) begin
            r_hide <= 1'b0;
        end else if (i_cmd.swap_commit) begin
            r_hide <= 1'b1;
        end
        if (i_cmd.push) begin
            r_ovf <= w_free_full;
        end
    end

    // Free stack storage; an entry not pushed since reset or pool reset reads as LAST_SLOT minus its index.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_free_mem[r_free_cnt[IDX_W-1:0]] <= w_slot_idx;
        end
        if (i_cmd.alloc_rd) begin
            r_free_rd <= r_free_vld[w_free_top] ? r_free_mem[w_free_top]
                                                : (LAST_SLOT - w_free_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pool_reset) begin
            r_free_vld <= '0;
        end else if (w_do_push) begin
            r_free_vld[r_free_cnt[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pool_reset) begin
            r_free_cnt <= CNT_MAX;
        end else if (i_cmd.alloc_commit) begin
            r_free_cnt <= w_free_m1;
        end else if (w_do_push) begin
            r_free_cnt <= r_free_cnt + CNT_W'(1);
        end
    end

    // Active list storage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_commit || i_cmd.swap_commit) begin
            r_act_mem[w_act_wr_addr] <= w_act_wr_data;
        end
        if (i_cmd.search_issue || i_cmd.swap_rd) begin
            r_act_rd <= r_act_mem[w_act_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.pool_reset) begin
            r_act_cnt <= '0;
        end else if (i_cmd.alloc_commit) begin
            r_act_cnt <= r_act_cnt + CNT_W'(1);
        end else if (i_cmd.swap_commit) begin
            r_act_cnt <= w_act_m1;
        end
    end

    // The search reads one entry per cycle and compares it on the next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.search_issue;
            if (i_cmd.search_start) begin
                r_idx <= '0;
            end else if (i_cmd.search_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_issue) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_status  <= i_cmd.status;
            r_out_granted <= r_granted;
            r_out_hide    <= r_hide;
            r_out_oam     <= r_hide ? OAM_W'({r_slot, 1'b0}) : '0;
            r_out_total   <= TOTAL_W'(r_act_cnt);
        end
    end

    assign o_status         = r_out_status;
    assign o_granted_slot   = r_out_granted;
    assign o_hide_valid     = r_out_hide;
    assign o_hide_oam_index = r_out_oam;
    assign o_active_total   = r_out_total;

    `SSA_ASSERT_SAME(a_free_cnt_bound, i_clk, i_rst_n, 1'b1, r_free_cnt <= CNT_MAX, "free count above slot count")
    `SSA_ASSERT_SAME(a_act_cnt_bound, i_clk, i_rst_n, 1'b1, r_act_cnt <= CNT_MAX, "active count above slot count")
    `SSA_ASSERT_SAME(a_swap_nonempty, i_clk, i_rst_n, i_cmd.swap_commit, r_act_cnt != '0, "swap with empty active list")
    `SSA_ASSERT_NEXT(a_alloc_grows, i_clk, i_rst_n, i_cmd.alloc_commit, r_act_cnt == CNT_W'($past(r_act_cnt) + CNT_W'(1)), "allocate did not grow active list")

endmodule

// ===== rtl/core/ssa_ctrl.sv =====
// Controller state machine of the sprite slot allocator.
// Depends on ssa_pkg and sprite_slot_allocator_defines.svh; drives ssa_datapath.
module ssa_ctrl
    import ssa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    `include "sprite_slot_allocator_defines.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SWAP   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_vld;
    logic                w_out_free;

    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_FINISH;
                n_status = ST_OK;
                case (i_sts.cmd)
                    CMD_RESET: begin
                        o_cmd.pool_reset = 1'b1;
                    end
                    CMD_ALLOC: begin
                        if (i_sts.free_empty || i_sts.active_full) begin
                            n_status = ST_NO_FREE;
                        end else begin
                            o_cmd.alloc_rd = 1'b1;
                            n_state        = S_ALLOC;
                        end
                    end
                    CMD_RELEASE: begin
                        if (i_sts.slot_oob) begin
                            n_status = ST_NOT_ACTIVE;
                        end else begin
                            o_cmd.push         = 1'b1;
                            o_cmd.search_start = 1'b1;
                            n_state            = S_SEARCH;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.alloc_commit = 1'b1;
                n_status           = ST_OK;
                n_state            = S_FINISH;
            end
            S_SEARCH: begin
                // A hit on the entry fetched last cycle wins over fetching the next one.
                if (i_sts.hit) begin
                    o_cmd.swap_rd = 1'b1;
                    n_state       = S_SWAP;
                end else if (i_sts.more) begin
                    o_cmd.search_issue = 1'b1;
                end else begin
                    n_status = i_sts.ovf ? ST_STACK_FULL : ST_NOT_ACTIVE;
                    n_state  = S_FINISH;
                end
            end
            S_SWAP: begin
                o_cmd.swap_commit = 1'b1;
                n_status          = i_sts.ovf ? ST_STACK_FULL : ST_OK;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= ST_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (o_cmd.load_result) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

    `SSA_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DECODE, "accepted beat not decoded")
    `SSA_ASSERT_NEXT(a_hit_swaps, i_clk, i_rst_n, (r_state == S_SEARCH) && i_sts.hit, r_state == S_SWAP, "search hit did not swap")
    `SSA_ASSERT_NEXT(a_finish_delivers, i_clk, i_rst_n, (r_state == S_FINISH) && w_out_free, r_out_vld && (r_state == S_IDLE), "result not presented")

endmodule

// ===== rtl/core/sprite_slot_allocator.sv =====
// Sprite slot allocator: a LIFO free stack of slot numbers and an unordered list
// of active slots. Each beat carries one command and yields one result beat.
// Reset, no-op and a refused allocate go from decode straight to the finish state,
// and a granted allocate passes through the allocate state first. A release of an
// in-range slot walks the active list linearly, reading one entry per cycle through
// its single read port, so its time grows with the number of active slots before it.
// A result waits in the output register while the next beat is accepted.
// Depends on ssa_pkg, ssa_ctrl and ssa_datapath.
module sprite_slot_allocator
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SSA_SLOT_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SLOT_W-1:0]   i_slot_id,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_granted_slot,
    output logic                o_hide_valid,
    output logic [OAM_W-1:0]    o_hide_oam_index,
    output logic [TOTAL_W-1:0]  o_active_total
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ssa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_command        (i_command),
        .i_slot_id        (i_slot_id),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_status         (o_status),
        .o_granted_slot   (o_granted_slot),
        .o_hide_valid     (o_hide_valid),
        .o_hide_oam_index (o_hide_oam_index),
        .o_active_total   (o_active_total)
    );

endmodule
